### rtl/cube_sphere_vertex_generator_unit_assert.svh
// ---------------------------------------------------------------------------
// Cube-sphere vertex generator assertion macros
// Clocked assertion wrappers that can be compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef CUBE_SPHERE_VERTEX_GENERATOR_UNIT_ASSERT_SVH
`define CUBE_SPHERE_VERTEX_GENERATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Assertion that is held off while reset is high.
`define CSVG_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Assertion that is also checked during reset.
`define CSVG_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSVG_ASSERT(label, clk, rst, prop, msg)
`define CSVG_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### rtl/csvg_pkg.sv
// ---------------------------------------------------------------------------
// Cube-sphere vertex generator package
// Default sizes, face codes and register map shared by the design.
// ---------------------------------------------------------------------------
package csvg_pkg;

  localparam int FRACTION_BITS_DEFAULT = 14;
  localparam int GRID_BITS_DEFAULT     = 8;

  // Register bus address width (byte address).
  localparam int PADDR_BITS = 3;

  // Word index of the resolution register.
  localparam logic [0:0] REG_RESOLUTION = 1'b0;

  // Face codes.
  localparam logic [2:0] FACE_TOP    = 3'd0;
  localparam logic [2:0] FACE_BOTTOM = 3'd1;
  localparam logic [2:0] FACE_FRONT  = 3'd2;
  localparam logic [2:0] FACE_BACK   = 3'd3;
  localparam logic [2:0] FACE_LEFT   = 3'd4;
  localparam logic [2:0] FACE_RIGHT  = 3'd5;

endpackage

### rtl/cube_sphere_vertex_generator_unit.sv
// ---------------------------------------------------------------------------
// Cube-sphere vertex generator
// Turns a grid point on a cube face into a unit-sphere vertex with normal,
// tangent, bitangent and texture coordinates.
// ---------------------------------------------------------------------------
// Usage:
// The item channel (item_valid/item_ready) carries one grid point per
// transfer: face, col and row. The vertex channel (vertex_valid/vertex_ready)
// returns exactly one vertex per accepted point, in order. Faces 6 and 7
// give an all-zero vertex. The resolution register sits at byte address 0
// of the APB-style port and may only be written while the block is idle.
// Throughput is one point per clock while vertex_ready stays high:
// every stage is a register with its own valid bit, and the normalization
// is done by FRACTION_BITS + 1 stages of a bit-serial square-root search,
// one result bit per stage, with the texture divisions riding alongside.
// A stalled receiver holds only the output stage; earlier stages keep
// moving until they close up on it, so bubbles are squeezed out and
// item_ready drops only when every stage holds a vertex.
// A synchronous reset empties the pipeline and sets resolution to one.
// ---------------------------------------------------------------------------
module cube_sphere_vertex_generator_unit #(
  parameter int FRACTION_BITS = csvg_pkg::FRACTION_BITS_DEFAULT,
  parameter int GRID_BITS     = csvg_pkg::GRID_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csvg_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // item channel
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [2:0]                    face,
  input  logic [GRID_BITS-1:0]          col,
  input  logic [GRID_BITS-1:0]          row,
  // vertex channel
  output logic                          vertex_valid,
  input  logic                          vertex_ready,
  output logic signed [FRACTION_BITS+1:0] pos_x,
  output logic signed [FRACTION_BITS+1:0] pos_y,
  output logic signed [FRACTION_BITS+1:0] pos_z,
  output logic signed [FRACTION_BITS+1:0] tan_x,
  output logic signed [FRACTION_BITS+1:0] tan_z,
  output logic signed [FRACTION_BITS+1:0] bitan_x,
  output logic signed [FRACTION_BITS+1:0] bitan_y,
  output logic signed [FRACTION_BITS+1:0] bitan_z,
  output logic [FRACTION_BITS:0]        tex_u,
  output logic [FRACTION_BITS:0]        tex_v
);

`include "cube_sphere_vertex_generator_unit_assert.svh"

  localparam int F   = FRACTION_BITS;
  localparam int G   = GRID_BITS;
  localparam int CW  = G + 2;             // signed face-plane coordinate
  localparam int SQW = 2 * G;             // squared magnitude
  localparam int SW  = 2 * G + 2;         // squared length
  localparam int QW  = F + 1;             // unsigned unit component
  localparam int PW  = 2 * F + 2 * G + 6; // search accumulators
  localparam int VW  = F + 2;             // signed vector output
  localparam int TW  = F + 1;             // texture coordinate
  localparam int NW  = G + F + 2;         // division remainder
  localparam int NS  = F + 7;             // pipeline stages

  localparam logic [TW-1:0] ONE = TW'(1) << F;

  typedef struct packed {
    logic [2:0]   face;
    logic [G-1:0] col;
    logic [G-1:0] row;
    logic [G-1:0] r;
    logic         bad;
  } st1_t;

  typedef struct packed {
    logic [2:0][G-1:0] m;
    logic [4:0]        neg;
    logic [G-1:0]      tu;
    logic [G-1:0]      tv;
    logic [G-1:0]      r;
    logic              bad;
  } st2_t;

  typedef struct packed {
    logic [4:0][SQW-1:0] sq;
    logic [SW-1:0]       s;
    logic [SW-1:0]       s2;
    logic [4:0][PW-1:0]  p;
    logic [4:0][PW-1:0]  qs;
    logic [4:0][QW-1:0]  q;
    logic [4:0]          neg;
    logic [NW-1:0]       ru;
    logic [NW-1:0]       rv;
    logic [G:0]          d;
    logic [TW-1:0]       qu;
    logic [TW-1:0]       qv;
    logic                pole;
    logic                bad;
  } it_t;

  typedef struct packed {
    logic signed [4:0][VW-1:0] v;
    logic [TW-1:0]             u;
    logic [TW-1:0]             w;
  } rd_t;

  typedef struct packed {
    logic signed [4:0][VW-1:0]   v;
    logic signed [3:0][2*VW-1:0] pr;
    logic [TW-1:0]               u;
    logic [TW-1:0]               w;
  } pr_t;

  typedef struct packed {
    logic signed [7:0][VW-1:0] v;
    logic [TW-1:0]             u;
    logic [TW-1:0]             w;
  } out_t;

  // Register port.
  logic [G-1:0] resolution;
  logic         reg_write;

  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite &&
                     (paddr[csvg_pkg::PADDR_BITS-1:2] == csvg_pkg::REG_RESOLUTION);

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution <= G'(1);
    end else if (reg_write) begin
      resolution <= pwdata[G-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[csvg_pkg::PADDR_BITS-1:2] == csvg_pkg::REG_RESOLUTION) begin
      prdata = 32'(resolution);
    end
  end

  // Stage valid bits and per-stage advance enables. A stage loads when it
  // is empty or when the stage after it moves on.
  logic [NS-1:0] vld;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = vertex_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign item_ready   = en[0];
  assign vertex_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= item_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 1: effective resolution and clamped grid point.
  st1_t         s1, s1_next;
  logic [G-1:0] r_eff;

  always_comb begin
    r_eff         = (resolution == '0) ? G'(1) : resolution;
    s1_next.face  = face;
    s1_next.r     = r_eff;
    s1_next.col   = (col > r_eff) ? r_eff : col;
    s1_next.row   = (row > r_eff) ? r_eff : row;
    s1_next.bad   = face > csvg_pkg::FACE_RIGHT;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1 <= s1_next;
    end
  end

  // Stage 2: place the point on its face.
  st2_t                 s2, s2_next;
  logic signed [CW-1:0] rr, aa, bb, c1, c2, c3;
  logic signed [CW-1:0] a1, a2, a3;

  always_comb begin
    rr = $signed({2'b00, s1.r});
    aa = $signed({1'b0, s1.col, 1'b0}) - rr;
    bb = $signed({1'b0, s1.row, 1'b0}) - rr;
    case (s1.face)
      csvg_pkg::FACE_TOP: begin
        c1 = aa; c2 = rr; c3 = bb;
      end
      csvg_pkg::FACE_BOTTOM: begin
        c1 = aa; c2 = -rr; c3 = bb;
      end
      csvg_pkg::FACE_FRONT: begin
        c1 = aa; c2 = bb; c3 = rr;
      end
      csvg_pkg::FACE_BACK: begin
        c1 = aa; c2 = bb; c3 = -rr;
      end
      csvg_pkg::FACE_LEFT: begin
        c1 = rr; c2 = bb; c3 = aa;
      end
      default: begin
        c1 = -rr; c2 = bb; c3 = aa;
      end
    endcase
    a1 = (c1 < 0) ? -c1 : c1;
    a2 = (c2 < 0) ? -c2 : c2;
    a3 = (c3 < 0) ? -c3 : c3;
    s2_next.m[0] = a1[G-1:0];
    s2_next.m[1] = a2[G-1:0];
    s2_next.m[2] = a3[G-1:0];
    // Signs of x, y, z, tangent x (which is -z) and tangent z (which is x).
    s2_next.neg  = {c1 < 0, c3 > 0, c3 < 0, c2 < 0, c1 < 0};
    if (s1.face inside {csvg_pkg::FACE_BOTTOM, csvg_pkg::FACE_FRONT,
                        csvg_pkg::FACE_RIGHT}) begin
      s2_next.tu = s1.r - s1.col;
    end else begin
      s2_next.tu = s1.col;
    end
    s2_next.tv  = s1.r - s1.row;
    s2_next.r   = s1.r;
    s2_next.bad = s1.bad;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2 <= s2_next;
    end
  end

  // Stage 3: squared lengths and the starting point of the searches.
  it_t              it [0:F+1];
  it_t              it0_next;
  logic [SQW-1:0]   sq0, sq1, sq2;

  always_comb begin
    sq0 = s2.m[0] * s2.m[0];
    sq1 = s2.m[1] * s2.m[1];
    sq2 = s2.m[2] * s2.m[2];
    it0_next.sq   = {sq0, sq2, sq2, sq1, sq0};
    it0_next.s    = SW'(sq0) + SW'(sq1) + SW'(sq2);
    it0_next.s2   = SW'(sq0) + SW'(sq2);
    it0_next.p    = '0;
    it0_next.qs   = '0;
    it0_next.q    = '0;
    it0_next.neg  = s2.neg;
    it0_next.ru   = (NW'(s2.tu) << (F + 1)) + NW'(s2.r);
    it0_next.rv   = (NW'(s2.tv) << (F + 1)) + NW'(s2.r);
    it0_next.d    = {s2.r, 1'b0};
    it0_next.qu   = '0;
    it0_next.qv   = '0;
    it0_next.pole = (sq0 == '0) && (sq2 == '0);
    it0_next.bad  = s2.bad;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      it[0] <= it0_next;
    end
  end

  // Search stages. Each stage decides one bit of every unit component:
  // with q the bits so far and t = q + 2^b, t*t*s is built from the running
  // q*q*s and q*s, so no stage needs a multiplier. The texture quotients
  // take one restoring-division bit per stage at the same time.
  for (genvar k = 0; k <= F; k++) begin : g_step
    localparam int B = F - k;
    it_t nx;

    always_comb begin
      logic [PW-1:0] su;
      logic [PW-1:0] cand;
      logic [PW-1:0] tgt;
      logic [NW-1:0] dsh;
      nx = it[k];
      for (int u = 0; u < 5; u++) begin
        su   = (u < 3) ? PW'(it[k].s) : PW'(it[k].s2);
        cand = it[k].p[u] + (it[k].qs[u] << (B + 1)) + (su << (2 * B));
        tgt  = PW'(it[k].sq[u]) << (2 * F);
        if (cand <= tgt) begin
          nx.p[u]    = cand;
          nx.qs[u]   = it[k].qs[u] + (su << B);
          nx.q[u][B] = 1'b1;
        end
      end
      dsh = NW'(it[k].d) << B;
      if (it[k].ru >= dsh) begin
        nx.ru    = it[k].ru - dsh;
        nx.qu[B] = 1'b1;
      end
      if (it[k].rv >= dsh) begin
        nx.rv    = it[k].rv - dsh;
        nx.qv[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en[3+k]) begin
        it[k+1] <= nx;
      end
    end
  end

  // Round stage: round to nearest, apply signs, pole and invalid face.
  rd_t rd, rd_next;

  always_comb begin
    logic [PW-1:0]        su;
    logic [PW-1:0]        lhs;
    logic [PW-1:0]        tgt4;
    logic [QW-1:0]        qr;
    logic signed [VW-1:0] mag;
    for (int u = 0; u < 5; u++) begin
      su   = (u < 3) ? PW'(it[F+1].s) : PW'(it[F+1].s2);
      lhs  = (it[F+1].p[u] << 2) + (it[F+1].qs[u] << 2) + su;
      tgt4 = PW'(it[F+1].sq[u]) << (2 * F + 2);
      qr   = it[F+1].q[u] + QW'(lhs <= tgt4);
      mag  = $signed({1'b0, qr});
      rd_next.v[u] = it[F+1].neg[u] ? -mag : mag;
    end
    if (it[F+1].pole) begin
      rd_next.v[3] = $signed(VW'(ONE));
      rd_next.v[4] = '0;
    end
    rd_next.u = it[F+1].qu;
    rd_next.w = it[F+1].qv;
    if (it[F+1].bad) begin
      rd_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[F+4]) begin
      rd <= rd_next;
    end
  end

  // Product stage: the four terms of position cross tangent. Elements of a
  // packed array read back unsigned, so each factor is taken as signed.
  pr_t pr, pr_next;

  always_comb begin
    pr_next.v     = rd.v;
    pr_next.u     = rd.u;
    pr_next.w     = rd.w;
    pr_next.pr[0] = $signed(rd.v[1]) * $signed(rd.v[4]);  // py * tz
    pr_next.pr[1] = $signed(rd.v[2]) * $signed(rd.v[3]);  // pz * tx
    pr_next.pr[2] = $signed(rd.v[0]) * $signed(rd.v[4]);  // px * tz
    pr_next.pr[3] = $signed(rd.v[1]) * $signed(rd.v[3]);  // py * tx
  end

  always_ff @(posedge clk) begin
    if (en[F+5]) begin
      pr <= pr_next;
    end
  end

  // Scale a product back to Q2.F, ties away from zero, clamped to one.
  function automatic logic signed [VW-1:0] scale_down(input logic signed [2*VW-1:0] v);
    logic [2*VW-1:0] mag;
    logic [2*VW-1:0] m;
    logic [VW-1:0]   res;
    mag = (v < 0) ? -v : v;
    m   = (mag + ((2*VW)'(1) << (F - 1))) >> F;
    if (m > (2*VW)'(ONE)) begin
      m = (2*VW)'(ONE);
    end
    res = m[VW-1:0];
    return (v < 0) ? -$signed(res) : $signed(res);
  endfunction

  // Output stage.
  out_t ov, ov_next;

  always_comb begin
    ov_next.v[4:0] = pr.v;
    ov_next.v[5]   = scale_down(pr.pr[0]);
    ov_next.v[6]   = scale_down(pr.pr[1] - pr.pr[2]);
    ov_next.v[7]   = scale_down(-pr.pr[3]);
    ov_next.u      = pr.u;
    ov_next.w      = pr.w;
  end

  always_ff @(posedge clk) begin
    if (en[F+6]) begin
      ov <= ov_next;
    end
  end

  assign pos_x   = ov.v[0];
  assign pos_y   = ov.v[1];
  assign pos_z   = ov.v[2];
  assign tan_x   = ov.v[3];
  assign tan_z   = ov.v[4];
  assign bitan_x = ov.v[5];
  assign bitan_y = ov.v[6];
  assign bitan_z = ov.v[7];
  assign tex_u   = ov.u;
  assign tex_v   = ov.w;

  // The input is only held off when the whole pipeline is full and stalled.
  `CSVG_ASSERT(a_ready_full, clk, rst, !item_ready |-> (vertex_valid && !vertex_ready && (&vld)), "item_ready low while the pipeline has room")
  // Texture coordinates never exceed one.
  `CSVG_ASSERT(a_tex_range, clk, rst, vertex_valid |-> ((tex_u <= ONE) && (tex_v <= ONE)), "texture coordinate above one")
  // The unit position x component stays within plus or minus one.
  `CSVG_ASSERT(a_pos_range, clk, rst, vertex_valid |-> ((pos_x <= $signed(VW'(ONE))) && (pos_x >= -$signed(VW'(ONE)))), "position x out of range")
  // Reset empties the pipeline on the next edge.
  `CSVG_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (vld == '0), "pipeline not empty after reset")

endmodule
